// File: rtl/dwpd_pkg.sv
// ============================================================================
// dwpd_pkg: shared types and constants of the two-wheel PID drive
// Holds the beat structs, configuration register codes and defaults, and the
// command group that the controller sends to the datapath.
// ============================================================================
`default_nettype none

package dwpd_pkg;

    // Default number of fraction bits of speeds, errors and drives.
    localparam int FRAC_BITS_DEF = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP     = 3'd0,
        CFG_GAIN_INTEG    = 3'd1,
        CFG_GAIN_DERIV    = 3'd2,
        CFG_STEER_CENTER  = 3'd3,
        CFG_DIFF_SLOPE    = 3'd4,
        CFG_DIFF_MAX      = 3'd5,
        CFG_DEAD_BAND     = 3'd6,
        CFG_SAT_THRESHOLD = 3'd7
    } cfg_idx_t;

    // Register reset values.
    localparam logic [31:0] GAIN_PROP_RST     = 32'd100663296;
    localparam logic [31:0] GAIN_INTEG_RST    = 32'd5033;
    localparam logic [31:0] GAIN_DERIV_RST    = 32'd35232154;
    localparam logic [15:0] STEER_CENTER_RST  = 16'd0;
    localparam logic [15:0] DIFF_SLOPE_RST    = 16'd138;
    localparam logic [15:0] DIFF_MAX_RST      = 16'd16056;
    localparam logic [15:0] DEAD_BAND_RST     = 16'd40;
    localparam logic [15:0] SAT_THRESHOLD_RST = 16'd120;

    // Duty limit of one motor direction.
    localparam logic [9:0] DUTY_LIM = 10'd990;

    // Input beat.
    typedef struct packed {
        logic signed [11:0] set_speed;
        logic [15:0]        steer_duty;
        logic signed [15:0] left_measured;
        logic signed [15:0] right_measured;
        logic               stop_request;
    } in_item_t;

    // Output beat.
    typedef struct packed {
        logic [9:0] left_fwd_duty;
        logic [9:0] left_rev_duty;
        logic [9:0] right_fwd_duty;
        logic [9:0] right_rev_duty;
    } out_item_t;

    // PID term under evaluation.
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } term_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;          // latch the input beat
        logic  prep;          // steering deviation and stop ramp
        logic  coef;          // differential coefficient
        logic  tgt_lo_issue;  // multiply speed by (1 - coef)
        logic  tgt_hi_issue;  // multiply speed by (1 + coef), capture low target
        logic  tgt_cap;       // capture high target
        logic  err;           // wheel error, integral and difference
        logic  term_load;     // load term operand and gain
        logic  mul_issue;     // multiply one 16-bit chunk
        logic  mul_first;     // chunk is the signed top chunk
        logic  acc_en;        // accumulate the registered product
        logic  sum_add;       // add finished term to the drive increment
        logic  drive;         // update the accumulated drive
        logic  duty;          // split drive into duties
        logic  out_load;      // present the result beat
        logic  wheel;         // 0 left, 1 right
        term_t term;
    } cmd_t;

endpackage

`default_nettype wire

// File: rtl/dwpd_ctrl.sv
// ============================================================================
// dwpd_ctrl: sequencer of the two-wheel PID drive
// Steps one tick through steering, targets and both wheels' P, I and D
// terms on the shared multiplier, then hands the result to the output stage.
// ============================================================================
`default_nettype none

module dwpd_ctrl #(
    parameter int FRAC_BITS = dwpd_pkg::FRAC_BITS_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_stall,
    input  wire            out_hold,
    output dwpd_pkg::cmd_t cmd
);

    // Chunks of 16 bits per term operand.
    localparam int DFW  = 19 + FRAC_BITS;
    localparam int NCH  = (DFW + 15) / 16;
    localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_COEF  = 14'b00000000000100,
        S_TLO   = 14'b00000000001000,
        S_THI   = 14'b00000000010000,
        S_TSEL  = 14'b00000000100000,
        S_ERR   = 14'b00000001000000,
        S_TLOAD = 14'b00000010000000,
        S_TMUL  = 14'b00000100000000,
        S_TLAST = 14'b00001000000000,
        S_TADD  = 14'b00010000000000,
        S_DRIVE = 14'b00100000000000,
        S_DUTY  = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t              state_reg, state_next;
    logic                wheel_reg, wheel_next;
    dwpd_pkg::term_t     term_reg, term_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;

    // State, wheel, term and chunk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wheel_reg <= 1'b0;
            term_reg  <= dwpd_pkg::TERM_P;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wheel_reg <= wheel_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.wheel  = wheel_reg;
        cmd.term   = term_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall   = 1'b0;
                wheel_next = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_COEF;
            end
            S_COEF:
            begin
                cmd.coef   = 1'b1;
                state_next = S_TLO;
            end
            S_TLO:
            begin
                cmd.tgt_lo_issue = 1'b1;
                state_next       = S_THI;
            end
            S_THI:
            begin
                cmd.tgt_hi_issue = 1'b1;
                state_next       = S_TSEL;
            end
            S_TSEL:
            begin
                cmd.tgt_cap = 1'b1;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.err    = 1'b1;
                term_next  = dwpd_pkg::TERM_P;
                state_next = S_TLOAD;
            end
            S_TLOAD:
            begin
                cmd.term_load = 1'b1;
                cnt_next      = '0;
                state_next    = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.mul_issue = 1'b1;
                cmd.mul_first = (cnt_reg == '0);
                cmd.acc_en    = (cnt_reg != '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NCH - 1))
                begin
                    state_next = S_TLAST;
                end
            end
            S_TLAST:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_TADD;
            end
            S_TADD:
            begin
                cmd.sum_add = 1'b1;
                case (term_reg)
                    dwpd_pkg::TERM_P:
                    begin
                        term_next  = dwpd_pkg::TERM_I;
                        state_next = S_TLOAD;
                    end
                    dwpd_pkg::TERM_I:
                    begin
                        term_next  = dwpd_pkg::TERM_D;
                        state_next = S_TLOAD;
                    end
                    default:
                    begin
                        state_next = S_DRIVE;
                    end
                endcase
            end
            S_DRIVE:
            begin
                cmd.drive  = 1'b1;
                state_next = S_DUTY;
            end
            S_DUTY:
            begin
                cmd.duty = 1'b1;
                if (wheel_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wheel_next = 1'b1;
                    state_next = S_ERR;
                end
            end
            S_DONE:
            begin
                if (!out_hold)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/dwpd_datapath.sv
// ============================================================================
// dwpd_datapath: arithmetic and state of the two-wheel PID drive
// Holds the configuration registers, the stop ramp, the per-wheel PID state,
// one shared 33x19 multiplier with a chunk accumulator, and the output stage.
// ============================================================================
`default_nettype none

module dwpd_datapath #(
    parameter int FRAC_BITS = dwpd_pkg::FRAC_BITS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire dwpd_pkg::cmd_t                cmd,
    input  wire dwpd_pkg::in_item_t            in_data,
    input  wire                                cfg_valid,
    input  wire [dwpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [dwpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                out_stall,
    output logic                               out_valid,
    output dwpd_pkg::out_item_t                out_data,
    output logic                               out_hold
);

    // Widths in Q.FRAC_BITS.
    localparam int SW   = 12 + FRAC_BITS;      // scaled set speed
    localparam int TGW  = 14 + FRAC_BITS;      // wheel target
    localparam int MW   = 16 + FRAC_BITS;      // scaled measurement
    localparam int EW   = 18 + FRAC_BITS;      // error
    localparam int IW   = 14 + FRAC_BITS;      // integral
    localparam int DFW  = 19 + FRAC_BITS;      // error difference
    localparam int NCH  = (DFW + 15) / 16;
    localparam int XRW  = 16 * NCH;            // term operand register
    localparam int AW   = 33 + XRW;            // full gain product
    localparam int TW   = AW - 24;             // one term
    localparam int SMW  = TW + 3;              // sum of three terms
    localparam int DRW  = 11 + FRAC_BITS;      // accumulated drive
    localparam int RPW  = 6 + FRAC_BITS;       // stop ramp
    localparam int PW   = 52;                  // multiplier product

    localparam logic signed [EW:0]  INTEG_LIM  = (EW+1)'(5000 * (1 << FRAC_BITS));
    localparam logic signed [SMW:0] DRIVE_LIM  = (SMW+1)'(1000 * (1 << FRAC_BITS));
    localparam logic [RPW-1:0]      RAMP_START = RPW'(50 * (1 << FRAC_BITS));
    localparam logic [RPW-1:0]      RAMP_FLOOR = RPW'(20 * (1 << FRAC_BITS));
    localparam logic [RPW-1:0]      RAMP_STEP  = RPW'((3 * (1 << FRAC_BITS) + 5) / 10);

    // Configuration registers.
    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic [15:0] center_reg, slope_reg, dmax_reg, dead_reg, sat_reg;

    // Tick and wheel state.
    dwpd_pkg::in_item_t        in_reg;
    logic                      dev_neg_reg;
    logic [15:0]               mag_reg;
    logic [15:0]               coef_reg;
    logic [RPW-1:0]            ramp_reg;
    logic signed [TGW-1:0]     tgt_lo_reg, tgt_hi_reg;
    logic signed [PW-1:0]      prod_reg;
    logic                      prod_first_reg;
    logic signed [XRW-1:0]     x_reg;
    logic [31:0]               g_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [SMW-1:0]     sum_reg;
    logic signed [EW-1:0]      err_reg;
    logic signed [DFW-1:0]     diff_reg;
    logic signed [IW-1:0]      integ_reg [2];
    logic signed [EW-1:0]      perr_reg [2];
    logic signed [DRW-1:0]     drive_reg [2];
    dwpd_pkg::out_item_t       res_reg;
    dwpd_pkg::out_item_t       out_reg;
    logic                      out_valid_reg;

    // Combinational intermediates.
    logic signed [16:0]        dev;
    logic [31:0]               slope_prod;
    logic [15:0]               coef_next;
    logic [RPW-1:0]            ramp_next;
    logic signed [SW-1:0]      s_val;
    logic [16:0]               factor_lo, factor_hi;
    logic signed [32:0]        mul_a;
    logic signed [18:0]        mul_b;
    logic [15:0]               chunk;
    logic signed [TGW-1:0]     tgt;
    logic signed [MW-1:0]      meas_sh;
    logic signed [EW-1:0]      err;
    logic signed [EW:0]        isum;
    logic signed [IW-1:0]      integ_next;
    logic signed [SMW:0]       dsum;
    logic signed [DRW-1:0]     drive_next;
    logic signed [DRW-1:0]     drv;
    logic [DRW-1:0]            drv_mag;
    logic [DRW-FRAC_BITS-1:0]  whole;
    logic [9:0]                duty_val;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= dwpd_pkg::GAIN_PROP_RST;
            gain_i_reg <= dwpd_pkg::GAIN_INTEG_RST;
            gain_d_reg <= dwpd_pkg::GAIN_DERIV_RST;
            center_reg <= dwpd_pkg::STEER_CENTER_RST;
            slope_reg  <= dwpd_pkg::DIFF_SLOPE_RST;
            dmax_reg   <= dwpd_pkg::DIFF_MAX_RST;
            dead_reg   <= dwpd_pkg::DEAD_BAND_RST;
            sat_reg    <= dwpd_pkg::SAT_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            case (dwpd_pkg::cfg_idx_t'(cfg_index))
                dwpd_pkg::CFG_GAIN_PROP:     gain_p_reg <= cfg_data;
                dwpd_pkg::CFG_GAIN_INTEG:    gain_i_reg <= cfg_data;
                dwpd_pkg::CFG_GAIN_DERIV:    gain_d_reg <= cfg_data;
                dwpd_pkg::CFG_STEER_CENTER:  center_reg <= cfg_data[15:0];
                dwpd_pkg::CFG_DIFF_SLOPE:    slope_reg  <= cfg_data[15:0];
                dwpd_pkg::CFG_DIFF_MAX:      dmax_reg   <= cfg_data[15:0];
                dwpd_pkg::CFG_DEAD_BAND:     dead_reg   <= cfg_data[15:0];
                dwpd_pkg::CFG_SAT_THRESHOLD: sat_reg    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Steering deviation, coefficient and stop ramp.
    always_comb
    begin
        dev        = signed'({1'b0, in_reg.steer_duty}) - signed'({1'b0, center_reg});
        slope_prod = slope_reg * mag_reg;
        if (mag_reg > sat_reg)
        begin
            coef_next = dmax_reg;
        end
        else if (mag_reg < dead_reg)
        begin
            coef_next = '0;
        end
        else if (slope_prod[31:16] != '0)
        begin
            coef_next = 16'hFFFF;
        end
        else
        begin
            coef_next = slope_prod[15:0];
        end
        // A ramp under the floor drops straight to zero.
        if (ramp_reg < RAMP_FLOOR)
        begin
            ramp_next = '0;
        end
        else
        begin
            ramp_next = ramp_reg - RAMP_STEP;
        end
    end

    // Shared multiplier operands: target scaling or one gain chunk.
    always_comb
    begin
        s_val     = {in_reg.set_speed, {FRAC_BITS{1'b0}}};
        factor_lo = 17'h10000 - {1'b0, coef_reg};
        factor_hi = 17'h10000 + {1'b0, coef_reg};
        chunk     = x_reg[XRW-1 -: 16];
        if (cmd.tgt_lo_issue)
        begin
            mul_a = 33'(s_val);
            mul_b = signed'({2'b00, factor_lo});
        end
        else if (cmd.tgt_hi_issue)
        begin
            mul_a = 33'(s_val);
            mul_b = signed'({2'b00, factor_hi});
        end
        else
        begin
            mul_a = signed'({1'b0, g_reg});
            // Only the top chunk carries the operand's sign.
            if (cmd.mul_first)
            begin
                mul_b = signed'({{3{chunk[15]}}, chunk});
            end
            else
            begin
                mul_b = signed'({3'b000, chunk});
            end
        end
    end

    // Wheel error, integral clamp and drive clamp.
    always_comb
    begin
        if (in_reg.stop_request)
        begin
            tgt = TGW'(signed'({1'b0, ramp_reg}));
        end
        else if (cmd.wheel == dev_neg_reg)
        begin
            tgt = tgt_lo_reg;
        end
        else
        begin
            tgt = tgt_hi_reg;
        end
        if (cmd.wheel)
        begin
            meas_sh = {in_reg.right_measured, {FRAC_BITS{1'b0}}};
        end
        else
        begin
            meas_sh = {in_reg.left_measured, {FRAC_BITS{1'b0}}};
        end
        err  = EW'(tgt) - EW'(meas_sh);
        isum = (EW+1)'(integ_reg[cmd.wheel]) + (EW+1)'(err);
        if (isum > INTEG_LIM)
        begin
            integ_next = IW'(INTEG_LIM);
        end
        else if (isum < -INTEG_LIM)
        begin
            integ_next = IW'(-INTEG_LIM);
        end
        else
        begin
            integ_next = IW'(isum);
        end
        dsum = (SMW+1)'(drive_reg[cmd.wheel]) + (SMW+1)'(sum_reg);
        if (dsum > DRIVE_LIM)
        begin
            drive_next = DRW'(DRIVE_LIM);
        end
        else if (dsum < -DRIVE_LIM)
        begin
            drive_next = DRW'(-DRIVE_LIM);
        end
        else
        begin
            drive_next = DRW'(dsum);
        end
    end

    // Integer part of the drive, truncated toward zero and limited.
    always_comb
    begin
        drv     = drive_reg[cmd.wheel];
        drv_mag = drv[DRW-1] ? DRW'(-drv) : DRW'(drv);
        whole   = drv_mag[DRW-1:FRAC_BITS];
        if (whole > (DRW-FRAC_BITS)'(dwpd_pkg::DUTY_LIM))
        begin
            duty_val = dwpd_pkg::DUTY_LIM;
        end
        else
        begin
            duty_val = whole[9:0];
        end
    end

    // Controlled state of the tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg     <= RAMP_START;
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            perr_reg[0]  <= '0;
            perr_reg[1]  <= '0;
            drive_reg[0] <= '0;
            drive_reg[1] <= '0;
        end
        else
        begin
            if (cmd.prep && in_reg.stop_request)
            begin
                ramp_reg <= ramp_next;
            end
            if (cmd.err)
            begin
                integ_reg[cmd.wheel] <= integ_next;
                perr_reg[cmd.wheel]  <= err;
            end
            if (cmd.drive)
            begin
                drive_reg[cmd.wheel] <= drive_next;
            end
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.prep)
        begin
            dev_neg_reg <= dev[16];
            mag_reg     <= dev[16] ? 16'(-dev) : dev[15:0];
        end
        if (cmd.coef)
        begin
            coef_reg <= coef_next;
        end
        if (cmd.tgt_lo_issue || cmd.tgt_hi_issue || cmd.mul_issue)
        begin
            prod_reg       <= mul_a * mul_b;
            prod_first_reg <= cmd.mul_first;
        end
        if (cmd.tgt_hi_issue)
        begin
            tgt_lo_reg <= TGW'(prod_reg >>> 16);
        end
        if (cmd.tgt_cap)
        begin
            tgt_hi_reg <= TGW'(prod_reg >>> 16);
        end
        if (cmd.err)
        begin
            err_reg  <= err;
            diff_reg <= DFW'(err) - DFW'(perr_reg[cmd.wheel]);
            sum_reg  <= '0;
        end
        if (cmd.term_load)
        begin
            case (cmd.term)
                dwpd_pkg::TERM_P:
                begin
                    x_reg <= XRW'(err_reg);
                    g_reg <= gain_p_reg;
                end
                dwpd_pkg::TERM_I:
                begin
                    x_reg <= XRW'(integ_reg[cmd.wheel]);
                    g_reg <= gain_i_reg;
                end
                default:
                begin
                    x_reg <= XRW'(diff_reg);
                    g_reg <= gain_d_reg;
                end
            endcase
        end
        else if (cmd.mul_issue)
        begin
            x_reg <= x_reg <<< 16;
        end
        // Chunks arrive top first, so each step shifts the partial sum up.
        if (cmd.acc_en)
        begin
            if (prod_first_reg)
            begin
                acc_reg <= AW'(prod_reg);
            end
            else
            begin
                acc_reg <= (acc_reg <<< 16) + AW'(prod_reg);
            end
        end
        if (cmd.sum_add)
        begin
            sum_reg <= sum_reg + SMW'(acc_reg >>> 24);
        end
        if (cmd.duty)
        begin
            if (cmd.wheel)
            begin
                res_reg.right_fwd_duty <= drv[DRW-1] ? 10'd0 : duty_val;
                res_reg.right_rev_duty <= drv[DRW-1] ? duty_val : 10'd0;
            end
            else
            begin
                res_reg.left_fwd_duty <= drv[DRW-1] ? 10'd0 : duty_val;
                res_reg.left_rev_duty <= drv[DRW-1] ? duty_val : 10'd0;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // Output stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_hold  = out_valid_reg && out_stall;

endmodule

`default_nettype wire

// File: rtl/differential_wheel_pid_drive.sv
// ============================================================================
// differential_wheel_pid_drive: two-wheel PID speed control with steering
// Top level: joins the sequencer and the datapath.
// ============================================================================
// Usage:
// One input beat per control tick carries the set speed, the steering servo
// duty, both encoder speeds and the stop flag. One output beat returns the
// forward and reverse duties of both motors. Both channels use valid/stall;
// in_stall is high while a tick is in progress.
// Each term operand splits into NCH = ceil((19 + FRAC_BITS) / 16) chunks
// of 16 bits, and a new beat is taken only once the previous tick has
// handed its result to the output register. The tick's length comes from the single
// 33x19 multiplier, which works through each wheel's three gain products
// 16 operand bits per cycle.
// The output register holds a finished beat while out_stall is high; the
// next tick may run meanwhile and waits at its end until the register frees.
// Configuration writes (cfg_ready is always high) belong in idle periods.
// Reset restores register defaults, sets the stop ramp to 50 and clears
// both wheels' integral, previous error and drive.
// ============================================================================
`default_nettype none

module differential_wheel_pid_drive #(
    parameter int FRAC_BITS = dwpd_pkg::FRAC_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire dwpd_pkg::in_item_t          in_data,
    output logic                             out_valid,
    input  wire                              out_stall,
    output dwpd_pkg::out_item_t              out_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [dwpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [dwpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    dwpd_pkg::cmd_t cmd;
    logic           out_hold;

    assign cfg_ready = 1'b1;

    // Sequencer.
    dwpd_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_hold (out_hold),
        .cmd      (cmd)
    );

    // Datapath.
    dwpd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_hold  (out_hold)
    );

endmodule

`default_nettype wire

// File: rtl/dwpd_checker.sv
// ============================================================================
// dwpd_checker: port-level checks of the two-wheel PID drive
// Watches the top level's channels and is bound to it below.
// ============================================================================
`default_nettype none

module dwpd_checker (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     in_valid,
    input wire                     in_stall,
    input wire                     out_valid,
    input wire                     out_stall,
    input wire dwpd_pkg::out_item_t out_data
);

    // A tick in progress blocks the next input beat.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a tick was in progress");

    // A stalled output beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped under stall");

    // A stalled output beat keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("output payload changed under stall");

    // Each motor drives one direction only, within the duty limit.
    a_duty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.left_fwd_duty == 10'd0 || out_data.left_rev_duty == 10'd0)
            && (out_data.right_fwd_duty == 10'd0 || out_data.right_rev_duty == 10'd0)
            && out_data.left_fwd_duty <= dwpd_pkg::DUTY_LIM
            && out_data.left_rev_duty <= dwpd_pkg::DUTY_LIM
            && out_data.right_fwd_duty <= dwpd_pkg::DUTY_LIM
            && out_data.right_rev_duty <= dwpd_pkg::DUTY_LIM)
        else $error("duty pair out of shape");

endmodule

bind differential_wheel_pid_drive dwpd_checker u_dwpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/differential_wheel_pid_drive_tb.sv
// ============================================================================
// differential_wheel_pid_drive_tb: self-checking bench of the two-wheel drive
// Feeds control ticks through a valid/stall driver, predicts each tick's
// duties with a bit-accurate model of the steering differential and the two
// wheel PID loops, and compares every output beat with the oldest prediction.
// ============================================================================

module differential_wheel_pid_drive_tb;

    import dwpd_pkg::*;

    localparam int FB        = 8;
    localparam longint ONE_Q = longint'(1) << FB;
    localparam int LATENCY   = 60;

    typedef struct {
        logic         is_cfg;
        cfg_idx_t     idx;
        logic [31:0]  data;
        in_item_t     item;
    } pending_t;

    typedef struct {
        longint prev_err;
        longint integ;
        longint drive;
    } wheel_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the configuration and controller state.
    logic [31:0] kp, ki, kd;
    logic [15:0] center, slope, cmax, dband, sat;
    longint ramp;
    wheel_state_t lw, rw;

    pending_t  beats_q[$];
    out_item_t duty_expect_q[$];
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   hold_cycles = 0;
    bit   failed = 0;

    differential_wheel_pid_drive dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Run limit far above the slowest correct run.
    initial
    begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint fshr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clampl(longint x, longint lim);
        return x > lim ? lim : (x < -lim ? -lim : x);
    endfunction

    // floor(g * x / 2^24) for an unsigned Q8.24 gain.
    function automatic longint gain_product(logic [31:0] g, longint x);
        longint hi, lo, gl;
        hi = fshr(x, 24);
        lo = x - (hi <<< 24);
        gl = longint'({32'd0, g});
        return gl * hi + ((gl * lo) >>> 24);
    endfunction

    function automatic void run_wheel(inout wheel_state_t w, input longint target,
                                      input longint meas, output logic [9:0] fwd,
                                      output logic [9:0] rev);
        longint err, p, i, d, whole;
        err = target - meas * ONE_Q;
        w.integ = clampl(w.integ + err, 5000 * ONE_Q);
        p = gain_product(kp, err);
        i = gain_product(ki, w.integ);
        d = gain_product(kd, err - w.prev_err);
        w.prev_err = err;
        w.drive = clampl(w.drive + p + i + d, 1000 * ONE_Q);
        whole = w.drive >= 0 ? (w.drive >>> FB) : -((-w.drive) >>> FB);
        whole = clampl(whole, 990);
        if (whole >= 0)
        begin
            fwd = whole[9:0];
            rev = '0;
        end
        else
        begin
            fwd = '0;
            rev = 10'(-whole);
        end
    endfunction

    // Duties of one control tick.
    function automatic out_item_t predict_tick(in_item_t t);
        out_item_t r;
        longint tl, tr, s, dev, mag, coef;
        if (t.stop_request)
        begin
            if (ramp < 20 * ONE_Q)
                ramp = 0;
            else
                ramp -= (3 * ONE_Q + 5) / 10;
            tl = ramp;
            tr = ramp;
        end
        else
        begin
            s = longint'(t.set_speed) * ONE_Q;
            dev = longint'({1'b0, t.steer_duty}) - longint'({1'b0, center});
            mag = dev < 0 ? -dev : dev;
            if (mag > longint'({1'b0, sat}))
                coef = cmax;
            else if (mag < longint'({1'b0, dband}))
                coef = 0;
            else
            begin
                coef = longint'({1'b0, slope}) * mag;
                if (coef > 65535)
                    coef = 65535;
            end
            tl = fshr(s * (65536 - coef), 16);
            tr = fshr(s * (65536 + coef), 16);
            if (dev < 0)
            begin
                s = tl;
                tl = tr;
                tr = s;
            end
        end
        run_wheel(lw, tl, longint'(t.left_measured), r.left_fwd_duty, r.left_rev_duty);
        run_wheel(rw, tr, longint'(t.right_measured), r.right_fwd_duty, r.right_rev_duty);
        return r;
    endfunction

    function automatic void write_register(cfg_idx_t idx, logic [31:0] v);
        case (idx)
            CFG_GAIN_PROP:     kp = v;
            CFG_GAIN_INTEG:    ki = v;
            CFG_GAIN_DERIV:    kd = v;
            CFG_STEER_CENTER:  center = v[15:0];
            CFG_DIFF_SLOPE:    slope = v[15:0];
            CFG_DIFF_MAX:      cmax = v[15:0];
            CFG_DEAD_BAND:     dband = v[15:0];
            CFG_SAT_THRESHOLD: sat = v[15:0];
            default: ;
        endcase
    endfunction

    // Driver: one beat at a time from the pending queue. A register write
    // waits until no tick is left in the block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                write_register(cfg_idx_t'(cfg_index), cfg_data);
                cfg_valid <= 1'b0;
            end
            else if (in_valid && !in_stall)
            begin
                duty_expect_q.push_back(predict_tick(in_data));
                in_valid <= 1'b0;
            end
            else if (!in_valid && !cfg_valid && beats_q.size() > 0 &&
                     (!beats_q[0].is_cfg || duty_expect_q.size() == 0) &&
                     $urandom_range(99) >= send_idle_pct)
            begin
                if (beats_q[0].is_cfg)
                begin
                    cfg_index <= beats_q[0].idx;
                    cfg_data  <= beats_q[0].data;
                    cfg_valid <= 1'b1;
                end
                else
                begin
                    in_data  <= beats_q[0].item;
                    in_valid <= 1'b1;
                end
                void'(beats_q.pop_front());
            end
        end
    end

    // Receiver stall: a long hold-off when requested, else random.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: compare each accepted output beat with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (duty_expect_q.size() == 0)
            begin
                $display("%0t: unexpected output beat %h", $time, out_data);
                failed <= 1'b1;
            end
            else
            begin
                if (out_data !== duty_expect_q[0])
                begin
                    $display("%0t: duty mismatch expected lf=%0d lr=%0d rf=%0d rr=%0d",
                             $time, duty_expect_q[0].left_fwd_duty,
                             duty_expect_q[0].left_rev_duty,
                             duty_expect_q[0].right_fwd_duty,
                             duty_expect_q[0].right_rev_duty);
                    $display("%0t:   actual lf=%0d lr=%0d rf=%0d rr=%0d", $time,
                             out_data.left_fwd_duty, out_data.left_rev_duty,
                             out_data.right_fwd_duty, out_data.right_rev_duty);
                    failed <= 1'b1;
                end
                void'(duty_expect_q.pop_front());
            end
        end
    end

    function automatic in_item_t tick(int spd, int duty, int lm, int rm, bit stop);
        in_item_t t;
        t.set_speed = 12'(spd);
        t.steer_duty = 16'(duty);
        t.left_measured = 16'(lm);
        t.right_measured = 16'(rm);
        t.stop_request = stop;
        return t;
    endfunction

    task automatic queue_tick(in_item_t t);
        pending_t p;
        p.is_cfg = 1'b0;
        p.idx = CFG_GAIN_PROP;
        p.data = '0;
        p.item = t;
        beats_q.push_back(p);
    endtask

    task automatic queue_cfg(cfg_idx_t idx, logic [31:0] v);
        pending_t p;
        p.is_cfg = 1'b1;
        p.idx = idx;
        p.data = v;
        p.item = '0;
        beats_q.push_back(p);
    endtask

    // Random tick: mostly moderate speeds near the steering center.
    function automatic in_item_t random_tick();
        int spd, duty, lm, rm;
        case ($urandom_range(3))
            0: spd = $urandom_range(4095) - 2048;
            default: spd = $urandom_range(200) - 100;
        endcase
        case ($urandom_range(3))
            0: duty = $urandom_range(65535);
            default: duty = int'(center) + $urandom_range(300) - 150;
        endcase
        if ($urandom_range(4) == 0)
        begin
            lm = $urandom_range(65535) - 32768;
            rm = $urandom_range(65535) - 32768;
        end
        else
        begin
            lm = spd + $urandom_range(40) - 20;
            rm = spd + $urandom_range(40) - 20;
        end
        return tick(spd, duty, lm, rm, $urandom_range(9) == 0);
    endfunction

    task automatic drain();
        while (beats_q.size() > 0 || in_valid || cfg_valid || duty_expect_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        kp = GAIN_PROP_RST;  ki = GAIN_INTEG_RST;  kd = GAIN_DERIV_RST;
        center = STEER_CENTER_RST;  slope = DIFF_SLOPE_RST;  cmax = DIFF_MAX_RST;
        dband = DEAD_BAND_RST;  sat = SAT_THRESHOLD_RST;
        ramp = 50 * ONE_Q;
        lw = '{0, 0, 0};
        rw = '{0, 0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings: extremes, dead band, cap, stop.
        queue_tick(tick(0, 0, 0, 0, 0));
        queue_tick(tick(2047, 0, 0, 0, 0));
        queue_tick(tick(-2048, 65535, 32767, -32768, 0));
        queue_tick(tick(100, 39, 100, 100, 0));
        queue_tick(tick(100, 40, 90, 110, 0));
        queue_tick(tick(100, 120, 100, 100, 0));
        queue_tick(tick(100, 121, -32768, 32767, 0));
        queue_tick(tick(-1, 65535, 0, 0, 0));
        for (int k = 0; k < 6; k++)
            queue_tick(tick(0, 0, 0, 0, 1));
        queue_tick(tick(2047, 80, -2048, 2047, 1));
        drain();

        // Negative deviation, overlapping cap and dead band, slope overflow.
        queue_cfg(CFG_STEER_CENTER, 32'd1000);
        queue_cfg(CFG_DIFF_SLOPE, 32'd65535);
        queue_cfg(CFG_DEAD_BAND, 32'd300);
        queue_cfg(CFG_SAT_THRESHOLD, 32'd200);
        queue_cfg(CFG_DIFF_MAX, 32'd65535);
        queue_tick(tick(500, 900, 0, 0, 0));
        queue_tick(tick(500, 1250, 0, 0, 0));
        queue_tick(tick(500, 1000, 0, 0, 0));
        queue_cfg(CFG_DEAD_BAND, 32'd0);
        queue_cfg(CFG_SAT_THRESHOLD, 32'd65535);
        queue_tick(tick(500, 1002, 10, 10, 0));
        queue_tick(tick(-700, 0, 10, 10, 0));
        queue_tick(tick(-700, 65535, 10, 10, 0));
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            // A different register set per phase, extremes included.
            case (phase)
                0:
                begin
                    queue_cfg(CFG_GAIN_PROP, 32'hFFFF_FFFF);
                    queue_cfg(CFG_GAIN_INTEG, 32'hFFFF_FFFF);
                    queue_cfg(CFG_GAIN_DERIV, 32'd0);
                    queue_cfg(CFG_STEER_CENTER, 32'd65535);
                    queue_cfg(CFG_DIFF_SLOPE, 32'd0);
                end
                1:
                begin
                    queue_cfg(CFG_GAIN_PROP, 32'd0);
                    queue_cfg(CFG_GAIN_INTEG, 32'd0);
                    queue_cfg(CFG_GAIN_DERIV, 32'hFFFF_FFFF);
                    queue_cfg(CFG_STEER_CENTER, 32'd0);
                    queue_cfg(CFG_DIFF_MAX, 32'd0);
                end
                default:
                begin
                    queue_cfg(CFG_GAIN_PROP, GAIN_PROP_RST);
                    queue_cfg(CFG_GAIN_INTEG, GAIN_INTEG_RST);
                    queue_cfg(CFG_GAIN_DERIV, GAIN_DERIV_RST);
                    queue_cfg(CFG_STEER_CENTER, 32'd32768);
                    queue_cfg(CFG_DIFF_SLOPE, DIFF_SLOPE_RST);
                    queue_cfg(CFG_DIFF_MAX, DIFF_MAX_RST);
                    queue_cfg(CFG_DEAD_BAND, DEAD_BAND_RST);
                    queue_cfg(CFG_SAT_THRESHOLD, SAT_THRESHOLD_RST);
                end
            endcase
            send_idle_pct = phase == 0 ? 21 : (phase == 1 ? 82 : 0);
            recv_idle_pct = phase == 0 ? 82 : (phase == 1 ? 21 : 0);
            // Predictor reads the center at prediction time; let writes land first.
            while (beats_q.size() > 0 || cfg_valid)
                @(posedge clk);
            for (int k = 0; k < 145; k++)
                queue_tick(random_tick());
            // Long receiver hold-off while the sender keeps offering ticks.
            if (phase == 2)
                hold_cycles = 400;
            drain();
        end

        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
